// File: src/hpq_pkg.sv
package hpq_pkg;

  // heap geometry
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned LVL_W    = $clog2(CNT_W);
  localparam int unsigned CHILD_W  = CNT_W + 1;

  // payload widths
  localparam int unsigned PRI_W    = 32;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned STATUS_W = 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  // one stored pair
  typedef struct packed {
    logic signed [PRI_W-1:0] pri;
    logic [ELEM_W-1:0]       elem;
  } pair_t;

  // request from the sequencer to the pair memory
  typedef struct packed {
    logic  we;
    addr_t waddr;
    pair_t wdata;
    addr_t raddr;
  } ram_req_t;

  // operation codes
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_ROOT,
    S_DEL_LAST,
    S_SFT_CHK,
    S_SFT_RDL,
    S_SFT_SEL,
    S_SFT_CMP,
    S_DONE
  } state_e;

  // index of the highest set bit, i.e. tree level of a 1-based position
  function automatic lvl_t level_of(input cnt_t pos);
    lvl_t lvl;
    lvl = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (pos[b]) lvl = lvl_t'(b);
    end
    return lvl;
  endfunction

endpackage

// File: src/hpq_ram.sv
module hpq_ram (
  input  logic              clk_i,
  input  hpq_pkg::ram_req_t req_i,
  output hpq_pkg::pair_t    rdata_o
);
  import hpq_pkg::*;

  pair_t mem [CAPACITY];
  pair_t rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/hpq_cmp.sv
module hpq_cmp (
  input  logic signed [hpq_pkg::PRI_W-1:0] a_i,
  input  logic signed [hpq_pkg::PRI_W-1:0] b_i,
  input  logic                             min_first_i,
  output logic                             a_wins_o
);
  import hpq_pkg::*;

  logic a_less;

  // signed compare, direction picked by the mode
  assign a_less   = (a_i < b_i);
  assign a_wins_o = (a_less == min_first_i);

endmodule

// File: src/binary_heap_priority_queue.sv
// channel  direction  handshake                    payload
// in       input      in_valid_i / in_stall_o      kind_i, priority_req_i, element_i
// out      output     out_valid_o / out_stall_i    status_o, top_element_o, occupancy_o
// cfg      input      cfg_we_i                     cfg_wdata_i (min_first)
// an insert walks the path from the root down to the new leaf, comparing at each level
// a remove takes the root, moves the last pair to the root and sifts it down the tree
// every step goes through the single read port of the pair memory and the shared compare
// reset empties the heap and selects smallest-first; memory contents are not cleared
// a beat is accepted in idle even while the previous result is stalled at the output
module binary_heap_priority_queue (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic signed [hpq_pkg::PRI_W-1:0]     priority_req_i,
  input  logic [hpq_pkg::ELEM_W-1:0]           element_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [hpq_pkg::STATUS_W-1:0]         status_o,
  output logic [hpq_pkg::ELEM_W-1:0]           top_element_o,
  output logic [hpq_pkg::CNT_W-1:0]            occupancy_o
);
  import hpq_pkg::*;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  logic    mode_q;
  pair_t   hold_q, hold_d;
  pair_t   child_q, child_d;
  cnt_t    pos_q, pos_d;
  lvl_t    lvl_q, lvl_d;
  cnt_t    node_q, node_d;
  cnt_t    cidx_q, cidx_d;
  logic [ELEM_W-1:0] top_q, top_d;
  status_e status_q, status_d;

  logic    out_valid_q;
  status_e out_status_q;
  logic [ELEM_W-1:0] out_top_q;
  cnt_t    out_occ_q;

  ram_req_t ram_req;
  pair_t    rdata;
  logic signed [PRI_W-1:0] cmp_a, cmp_b;
  logic     a_wins;

  logic        accept;
  logic        out_free;
  cnt_t        path_node;
  addr_t       path_slot;
  logic [CHILD_W-1:0] left_idx, right_idx, count_ext;

  hpq_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  hpq_cmp u_cmp (
    .a_i         (cmp_a),
    .b_i         (cmp_b),
    .min_first_i (mode_q),
    .a_wins_o    (a_wins)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // tree addressing helpers
  assign path_node = pos_q >> lvl_q;
  assign path_slot = addr_t'(path_node - cnt_t'(1));
  assign left_idx  = {node_q, 1'b0};
  assign right_idx = left_idx + CHILD_W'(1);
  assign count_ext = {1'b0, count_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_INSERT) begin
            state_d = (count_q >= cnt_t'(CAPACITY)) ? S_DONE : S_INS_RD;
          end else begin
            state_d = (count_q == '0) ? S_DONE : S_DEL_ROOT;
          end
        end
      end
      S_INS_RD:   state_d = (lvl_q == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP:  state_d = S_INS_RD;
      S_DEL_ROOT: state_d = S_DEL_LAST;
      S_DEL_LAST: state_d = S_SFT_CHK;
      S_SFT_CHK:  state_d = (left_idx > count_ext) ? S_DONE : S_SFT_RDL;
      S_SFT_RDL:  state_d = (right_idx > count_ext) ? S_SFT_CMP : S_SFT_SEL;
      S_SFT_SEL:  state_d = S_SFT_CMP;
      S_SFT_CMP:  state_d = a_wins ? S_SFT_CHK : S_DONE;
      S_DONE:     state_d = out_free ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath, memory requests and compare operands
  always_comb begin
    count_d  = count_q;
    hold_d   = hold_q;
    child_d  = child_q;
    pos_d    = pos_q;
    lvl_d    = lvl_q;
    node_d   = node_q;
    cidx_d   = cidx_q;
    top_d    = top_q;
    status_d = status_q;
    ram_req  = '0;
    cmp_a    = hold_q.pri;
    cmp_b    = rdata.pri;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          top_d    = '0;
          status_d = ST_DONE;
          hold_d   = '{pri: priority_req_i, elem: element_i};
          pos_d    = count_q + cnt_t'(1);
          lvl_d    = level_of(count_q + cnt_t'(1));
          // root read, used by a remove
          ram_req.raddr = '0;
          if (kind_i == KIND_INSERT) begin
            if (count_q >= cnt_t'(CAPACITY)) status_d = ST_FULL;
          end else begin
            if (count_q == '0) status_d = ST_EMPTY;
          end
        end
      end
      // walk down the path to the new leaf
      S_INS_RD: begin
        if (lvl_q == '0) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = addr_t'(pos_q - cnt_t'(1));
          ram_req.wdata = hold_q;
          count_d       = pos_q;
        end else begin
          ram_req.raddr = path_slot;
        end
      end
      S_INS_CMP: begin
        if (a_wins) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = path_slot;
          ram_req.wdata = hold_q;
          hold_d        = rdata;
        end
        lvl_d = lvl_q - lvl_t'(1);
      end
      // removal: root arrives, fetch last pair
      S_DEL_ROOT: begin
        top_d         = rdata.elem;
        ram_req.raddr = addr_t'(count_q - cnt_t'(1));
      end
      S_DEL_LAST: begin
        hold_d  = rdata;
        count_d = count_q - cnt_t'(1);
        node_d  = cnt_t'(1);
      end
      // sift down with the moving pair held in a register
      S_SFT_CHK: begin
        if (left_idx > count_ext) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = addr_t'(node_q - cnt_t'(1));
          ram_req.wdata = hold_q;
        end else begin
          ram_req.raddr = addr_t'(left_idx - CHILD_W'(1));
        end
      end
      S_SFT_RDL: begin
        child_d       = rdata;
        cidx_d        = cnt_t'(left_idx);
        ram_req.raddr = addr_t'(right_idx - CHILD_W'(1));
      end
      S_SFT_SEL: begin
        cmp_a = child_q.pri;
        cmp_b = rdata.pri;
        if (!a_wins) begin
          child_d = rdata;
          cidx_d  = cnt_t'(right_idx);
        end
      end
      S_SFT_CMP: begin
        cmp_a         = child_q.pri;
        cmp_b         = hold_q.pri;
        ram_req.we    = 1'b1;
        ram_req.waddr = addr_t'(node_q - cnt_t'(1));
        if (a_wins) begin
          ram_req.wdata = child_q;
          node_d        = cidx_q;
        end else begin
          ram_req.wdata = hold_q;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      mode_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    hold_q   <= hold_d;
    child_q  <= child_d;
    pos_q    <= pos_d;
    lvl_q    <= lvl_d;
    node_q   <= node_d;
    cidx_q   <= cidx_d;
    top_q    <= top_d;
    status_q <= status_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_status_q <= status_q;
      out_top_q    <= top_q;
      out_occ_q    <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign top_element_o = out_top_q;
  assign occupancy_o   = out_occ_q;

endmodule
